// File: rtl/core/dws_pkg.sv
// Package for the diamond window sum block: sizes, payload structs, opcodes,
// controller states and the command/status bundles. No dependencies.
package dws_pkg;

  localparam int MaxRows  = 64;
  localparam int MaxCols  = 64;
  localparam int CellBits = 8;
  localparam int Depth    = MaxRows * MaxCols;
  localparam int AddrW    = $clog2(Depth);
  localparam int DimW     = 7;
  localparam int ScoreW   = 20;
  localparam int CountW   = 13;
  localparam int AccW     = 21;
  localparam int CfgIdxW  = 2;

  localparam logic [ScoreW-1:0] ScoreMax = '1;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_SUMMARY = 2'd0,
    KIND_POS     = 2'd1,
    KIND_DONE    = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROWS   = 2'd0,
    REG_COLS   = 2'd1,
    REG_RADIUS = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL,
    ST_ROW,
    ST_RD,
    ST_ACC,
    ST_STORE,
    ST_FSCAN,
    ST_FCHK,
    ST_FDIV
  } state_e;

  typedef struct packed {
    logic                op;
    logic [CellBits-1:0] cell_value;
    logic                last_cell;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ScoreW-1:0] best_score;
    logic [CountW-1:0] best_count;
    logic [DimW-1:0]   row;
    logic [DimW-1:0]   col;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic store_cell;   // write input cell, advance load pointer
    logic start_comp;   // clear best/count, position to cell 0
    logic start_row;    // set up window row range for current cell
    logic rd_grid;      // issue grid read at current window point
    logic acc;          // add read data, advance window column
    logic store_score;  // write score, update best, advance cell
    logic start_fetch;  // set scan pointer from fetch pointer
    logic rd_score;     // issue score read at scan pointer
    logic chk_score;    // compare and advance scan pointer
    logic div_start;    // load the hit index into the row/column divider
    logic div_step;     // one shift-subtract step of the divider
    logic load_sum;     // capture summary result
    logic load_pos;     // capture position result
    logic load_done;    // capture done result
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic row_last;   // window row is the last one of the window
    logic col_last;   // window column is the last of its row
    logic cell_last;  // current cell is the last of the grid
    logic scan_end;   // scan pointer reached total
    logic hit;        // score read equals best
    logic div_last;   // divider performs its final step this cycle
  } sts_t;

endpackage

// File: rtl/core/dws_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module dws_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/core/dws_ctrl.sv
// Controller state machine for the diamond window sum block.
// Depends on dws_pkg.
module dws_ctrl import dws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid,
  input  in_item_t in_item_i,
  input  logic     out_busy_i,
  input  sts_t     sts_i,
  output logic     in_ready,
  output cmd_t     cmd_o
);
  state_e state_q, state_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid && !out_busy_i) begin
          if (in_item_i.op == OP_FETCH) begin
            state_d = ST_FSCAN;
          end else if (in_item_i.last_cell) begin
            state_d = ST_CELL;
          end
        end
      end
      ST_CELL:  state_d = ST_ROW;
      ST_ROW:   state_d = ST_RD;
      ST_RD:    state_d = ST_ACC;
      ST_ACC: begin
        if (!sts_i.col_last) begin
          state_d = ST_RD;
        end else if (!sts_i.row_last) begin
          state_d = ST_ROW;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: state_d = sts_i.cell_last ? ST_IDLE : ST_CELL;
      ST_FSCAN: state_d = sts_i.scan_end ? ST_IDLE : ST_FCHK;
      ST_FCHK:  state_d = sts_i.hit ? ST_FDIV : ST_FSCAN;
      ST_FDIV:  state_d = sts_i.div_last ? ST_IDLE : ST_FDIV;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o    = '0;
    in_ready = (state_q == ST_IDLE) && !out_busy_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid && !out_busy_i) begin
          if (in_item_i.op == OP_FETCH) begin
            cmd_o.start_fetch = 1'b1;
          end else begin
            cmd_o.store_cell = 1'b1;
            cmd_o.start_comp = in_item_i.last_cell;
          end
        end
      end
      ST_CELL:  cmd_o.start_row = 1'b1;
      ST_ROW:   cmd_o.start_row = 1'b0;
      ST_RD:    cmd_o.rd_grid = 1'b1;
      ST_ACC:   cmd_o.acc = 1'b1;
      ST_STORE: begin
        cmd_o.store_score = 1'b1;
        cmd_o.load_sum    = sts_i.cell_last;
      end
      ST_FSCAN: begin
        cmd_o.rd_score  = !sts_i.scan_end;
        cmd_o.load_done = sts_i.scan_end;
      end
      ST_FCHK: begin
        cmd_o.chk_score = 1'b1;
        cmd_o.div_start = sts_i.hit;
      end
      ST_FDIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.load_pos = sts_i.div_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// File: rtl/core/dws_dp.sv
// Datapath: configuration, grid and score stores, window walk, best tracking,
// fetch scan and output register. Depends on dws_pkg and dws_ram.
module dws_dp import dws_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i,
  input  in_item_t           in_item_i,
  input  cmd_t               cmd_i,
  input  logic               out_ready,
  output sts_t               sts_o,
  output logic               out_busy_o,
  output logic               out_valid,
  output out_item_t          out_item_o
);
  localparam int PosW = AddrW + 1;
  localparam int CoordW = $clog2(MaxRows > MaxCols ? MaxRows : MaxCols) + 1;
  localparam int DivCntW = $clog2(PosW);

  logic [DimW-1:0] rows_cfg_q, cols_cfg_q, radius_q;
  logic [CoordW-1:0] rows_e, cols_e;
  logic [PosW-1:0] total;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= DimW'(64);
      cols_cfg_q <= DimW'(64);
      radius_q   <= DimW'(1);
    end else if (cfg_valid) begin
      case (reg_e'(cfg_index_i))
        REG_ROWS:   rows_cfg_q <= cfg_data_i;
        REG_COLS:   cols_cfg_q <= cfg_data_i;
        REG_RADIUS: radius_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp configuration into 1..max.
  always_comb begin
    if (rows_cfg_q == '0) rows_e = CoordW'(1);
    else if (32'(rows_cfg_q) > MaxRows) rows_e = CoordW'(MaxRows);
    else rows_e = CoordW'(rows_cfg_q);
    if (cols_cfg_q == '0) cols_e = CoordW'(1);
    else if (32'(cols_cfg_q) > MaxCols) cols_e = CoordW'(MaxCols);
    else cols_e = CoordW'(cols_cfg_q);
  end

  assign total = PosW'(rows_e) * PosW'(cols_e);

  // Pointers and walk state.
  logic [AddrW-1:0]  load_ptr_q;
  logic [PosW-1:0]   fetch_ptr_q, scan_q;
  logic [CoordW-1:0] r_q, c_q, i_q, j_q, j1_q, i1_q;
  logic [AddrW-1:0]  cell_addr_q, row_base_q;
  logic [AccW-1:0]   sum_q;
  logic [ScoreW-1:0] best_q;
  logic [CountW-1:0] count_q;
  logic              first_row_q;  // the row setup that follows is the first of a cell

  // Window row bounds for the current cell.
  logic [CoordW+1:0] d_w, r_w, c_w, i0_w, i1_w, di_w, span_w, j0_w, j1_w, ni_w;
  always_comb begin
    d_w  = (CoordW+2)'(radius_q);
    r_w  = (CoordW+2)'(r_q);
    c_w  = (CoordW+2)'(c_q);
    i0_w = (r_w > d_w) ? r_w - d_w : '0;
    i1_w = (r_w + d_w < (CoordW+2)'(rows_e)) ? r_w + d_w : (CoordW+2)'(rows_e) - 1'b1;
    // Next window row: first row on cell start, else i+1.
    ni_w = first_row_q ? i0_w : (CoordW+2)'(i_q) + 1'b1;
    di_w = (ni_w > r_w) ? ni_w - r_w : r_w - ni_w;
    span_w = d_w - di_w;
    j0_w = (c_w > span_w) ? c_w - span_w : '0;
    j1_w = (c_w + span_w < (CoordW+2)'(cols_e)) ? c_w + span_w
                                                 : (CoordW+2)'(cols_e) - 1'b1;
  end

  logic row_setup_q;  // ST_ROW cycle follows: compute row bounds
  logic [AddrW-1:0] grid_addr;
  logic [CellBits-1:0] grid_rdata;
  logic [ScoreW-1:0] score_rdata, score_val;
  logic grid_we;

  assign score_val = (sum_q > AccW'(ScoreMax)) ? ScoreMax : sum_q[ScoreW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_ptr_q  <= '0;
      fetch_ptr_q <= '0;
      best_q      <= '0;
      count_q     <= '0;
      row_setup_q <= 1'b0;
      first_row_q <= 1'b0;
    end else begin
      row_setup_q <= cmd_i.start_row || (cmd_i.acc && sts_o.col_last && !sts_o.row_last);
      first_row_q <= cmd_i.start_row;
      if (cmd_i.store_cell) begin
        load_ptr_q <= cmd_i.start_comp ? '0 : load_ptr_q + 1'b1;
      end
      if (cmd_i.start_comp) begin
        best_q      <= '0;
        count_q     <= '0;
        fetch_ptr_q <= '0;
      end
      if (cmd_i.store_score) begin
        if (score_val > best_q) begin
          best_q  <= score_val;
          count_q <= CountW'(1);
        end else if (score_val == best_q && count_q != CountMax) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (cmd_i.load_pos) begin
        fetch_ptr_q <= scan_q + 1'b1;
      end
    end
  end

  // Restoring divider that splits the hit index into row and column.
  logic [PosW-1:0]    div_quo_q, div_quo_d;
  logic [CoordW-1:0]  div_rem_q, div_rem_d;
  logic [DivCntW-1:0] div_cnt_q;
  logic [CoordW:0]    div_sh;
  logic               div_ge;
  always_comb begin
    div_sh    = {div_rem_q, div_quo_q[PosW-1]};
    div_ge    = (div_sh >= (CoordW+1)'(cols_e));
    div_rem_d = div_ge ? CoordW'(div_sh - (CoordW+1)'(cols_e)) : CoordW'(div_sh);
    div_quo_d = {div_quo_q[PosW-2:0], div_ge};
  end

  // Walk registers (payload, no reset).
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_comp) begin
      r_q <= '0;
      c_q <= '0;
      cell_addr_q <= '0;
    end
    if (cmd_i.start_row) begin
      sum_q <= '0;
    end
    if (row_setup_q) begin
      i_q  <= CoordW'(ni_w);
      i1_q <= CoordW'(i1_w);
      j_q  <= CoordW'(j0_w);
      j1_q <= CoordW'(j1_w);
      row_base_q <= AddrW'(ni_w) * AddrW'(cols_e);
    end
    if (cmd_i.acc) begin
      sum_q <= sum_q + AccW'(grid_rdata);
      j_q   <= j_q + 1'b1;
    end
    if (cmd_i.store_score) begin
      cell_addr_q <= cell_addr_q + 1'b1;
      if (c_q == cols_e - 1'b1) begin
        c_q <= '0;
        r_q <= r_q + 1'b1;
      end else begin
        c_q <= c_q + 1'b1;
      end
    end
    if (cmd_i.start_fetch) begin
      scan_q <= fetch_ptr_q;
    end
    if (cmd_i.chk_score && !sts_o.hit) begin
      scan_q <= scan_q + 1'b1;
    end
    if (cmd_i.div_start) begin
      div_quo_q <= scan_q;
      div_rem_q <= '0;
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      div_quo_q <= div_quo_d;
      div_rem_q <= div_rem_d;
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  assign sts_o.col_last  = (j_q == j1_q);
  assign sts_o.row_last  = (i_q == i1_q);
  assign sts_o.cell_last = (r_q == rows_e - 1'b1) && (c_q == cols_e - 1'b1);
  assign sts_o.scan_end  = (scan_q >= total);
  assign sts_o.hit       = (score_rdata == best_q);
  assign sts_o.div_last  = (div_cnt_q == DivCntW'(PosW - 1));

  // Grid store: written on load, read during the window walk.
  assign grid_we   = cmd_i.store_cell;
  assign grid_addr = grid_we ? load_ptr_q : row_base_q + AddrW'(j_q);

  dws_ram #(.Width(CellBits), .Depth(Depth)) u_grid (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .addr_i  (grid_addr),
    .wdata_i (in_item_i.cell_value),
    .rdata_o (grid_rdata)
  );

  // Score store: written per cell, read by the fetch scan.
  dws_ram #(.Width(ScoreW), .Depth(Depth)) u_score (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store_score),
    .addr_i  (cmd_i.store_score ? cell_addr_q : scan_q[AddrW-1:0]),
    .wdata_i (score_val),
    .rdata_o (score_rdata)
  );

  // Output register; summary uses the best value including this last cell.
  logic [ScoreW-1:0] best_now;
  logic [CountW-1:0] count_now;
  always_comb begin
    best_now  = best_q;
    count_now = count_q;
    if (score_val > best_q) begin
      best_now  = score_val;
      count_now = CountW'(1);
    end else if (score_val == best_q && count_q != CountMax) begin
      count_now = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid <= 1'b0;
    end else if (cmd_i.load_sum || cmd_i.load_pos || cmd_i.load_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The position result takes the quotient and remainder of the final step.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sum) begin
      out_item_o <= '{kind: KIND_SUMMARY, best_score: best_now, best_count: count_now,
                      row: '0, col: '0};
    end else if (cmd_i.load_pos) begin
      out_item_o <= '{kind: KIND_POS, best_score: best_q, best_count: count_q,
                      row: DimW'(div_quo_d + 1'b1), col: div_rem_d + 1'b1};
    end else if (cmd_i.load_done) begin
      out_item_o <= '{kind: KIND_DONE, best_score: best_q, best_count: count_q,
                      row: '0, col: '0};
    end
  end

  assign out_busy_o = out_valid && !out_ready;
endmodule

// File: rtl/core/diamond_window_sum_argmax.sv
// Top level of the diamond window sum block with best-score positions.
// Depends on dws_pkg, dws_ctrl, dws_dp, dws_ram.
//
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_item_t (op, cell_value, last_cell)
// out       output     out_valid / out_ready  out_item_t (kind, score, count, row, col)
// cfg       input      cfg_valid / cfg_ready  cfg_index_i, cfg_data_i
//
// A last load runs the score pass: per cell a setup step, a row setup for
// each window row, a grid read and an accumulate for each window point and
// a store step. A fetch reads and checks the scores one at a time; a hit
// then runs the divider for row and column, and a fetch with no hit left
// ends in the scan state. Reset is asynchronous; the stores hold no reset.
// The result waits in an output register; a new item is taken only once
// any earlier result has been taken or is being taken.
module diamond_window_sum_argmax import dws_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_item_i,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_item_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_data_i
);
  cmd_t cmd;
  sts_t sts;
  logic out_busy;

  assign cfg_ready = 1'b1;

  dws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid   (in_valid),
    .in_item_i  (in_item_i),
    .out_busy_i (out_busy),
    .sts_i      (sts),
    .in_ready   (in_ready),
    .cmd_o      (cmd)
  );

  dws_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid   (cfg_valid),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .out_ready   (out_ready),
    .sts_o       (sts),
    .out_busy_o  (out_busy),
    .out_valid   (out_valid),
    .out_item_o  (out_item_o)
  );

  // Only one result is captured at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load_sum, cmd.load_pos, cmd.load_done}))
    else $error("two results captured at once");

  // No input item is taken while a result is stuck.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken under output stall");

  // A position result always carries a nonzero row and column.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_item_o.kind == KIND_POS) |-> (out_item_o.row != '0 && out_item_o.col != '0))
    else $error("position result with zero coordinate");
endmodule

// File: tb/diamond_window_sum_argmax_tb.sv
// Self-checking testbench for diamond_window_sum_argmax: grid loads, window-sum
// summaries and best-position fetches, checked against an in-bench predictor.
// Depends on dws_pkg and the diamond_window_sum_argmax RTL.
module diamond_window_sum_argmax_tb;
  import dws_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 500000;
  localparam int RandItems  = 320;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_item_i = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_item_o;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DimW-1:0]    cfg_data_i = '0;

  diamond_window_sum_argmax u_top (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_item_i,
    .out_valid, .out_ready, .out_item_o,
    .cfg_valid, .cfg_ready, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // Predictor state: the grid, the scores, the pointers and the registers.
  logic [CellBits-1:0] grid_mem [Depth];
  logic [ScoreW-1:0]   score_mem [Depth];
  int unsigned         load_ptr, fetch_ptr;
  logic [ScoreW-1:0]   best_sum;
  logic [CountW-1:0]   best_cnt;
  logic [DimW-1:0]     rows_reg, cols_reg, radius_reg;

  out_item_t expected_q [$];
  in_item_t  pending_q [$];
  int unsigned pushed_cnt, accepted_cnt, cfg_cnt, result_cnt, err_cnt, idle_cycles;
  bit          in_taken;
  int          burst_left, gap_left;
  int unsigned ready_cyc;
  int          ready_mode;

  function automatic int unsigned eff_dim(logic [DimW-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    return (v > lim) ? lim : v;
  endfunction

  // Sum of the cells within Manhattan distance radius, clipped at the edges.
  function automatic logic [ScoreW-1:0] diamond_sum(int r, int c, int rows, int cols);
    longint sum;
    int d, i0, i1, di, span, j0, j1;
    sum = 0;
    d = radius_reg;
    i0 = (r > d) ? r - d : 0;
    i1 = (r + d < rows) ? r + d : rows - 1;
    for (int i = i0; i <= i1; i++) begin
      di = (i > r) ? i - r : r - i;
      span = d - di;
      j0 = (c > span) ? c - span : 0;
      j1 = (c + span < cols) ? c + span : cols - 1;
      for (int j = j0; j <= j1; j++) sum += grid_mem[(i * cols + j) % Depth];
    end
    return (sum > ScoreMax) ? ScoreMax : sum[ScoreW-1:0];
  endfunction

  // Score every cell and track the best score and how many cells reach it.
  function automatic void score_grid();
    int unsigned rows, cols;
    logic [ScoreW-1:0] s;
    rows = eff_dim(rows_reg, MaxRows);
    cols = eff_dim(cols_reg, MaxCols);
    best_sum = '0;
    best_cnt = '0;
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        s = diamond_sum(r, c, rows, cols);
        score_mem[r * cols + c] = s;
        if (s > best_sum) begin
          best_sum = s;
          best_cnt = CountW'(1);
        end else if (s == best_sum && best_cnt < CountMax) begin
          best_cnt++;
        end
      end
    end
  endfunction

  // Apply one accepted item to the predictor and queue the result it causes.
  function automatic void predict_item(in_item_t it);
    out_item_t res;
    int unsigned rows, cols, total, p;
    res = '0;
    if (op_e'(it.op) == OP_LOAD) begin
      grid_mem[load_ptr] = it.cell_value;
      load_ptr = (load_ptr + 1) % Depth;
      if (!it.last_cell) return;
      score_grid();
      load_ptr = 0;
      fetch_ptr = 0;
      res.kind = KIND_SUMMARY;
    end else begin
      rows = eff_dim(rows_reg, MaxRows);
      cols = eff_dim(cols_reg, MaxCols);
      total = rows * cols;
      res.kind = KIND_DONE;
      for (p = fetch_ptr; p < total; p++) begin
        if (score_mem[p] == best_sum) begin
          fetch_ptr = p + 1;
          res.kind = KIND_POS;
          res.row = DimW'(p / cols + 1);
          res.col = DimW'(p % cols + 1);
          break;
        end
      end
    end
    res.best_score = best_sum;
    res.best_count = best_cnt;
    expected_q.push_back(res);
  endfunction

  function automatic void check_result(out_item_t got);
    out_item_t exp_item;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %p", $realtime, got);
      err_cnt++;
      return;
    end
    exp_item = expected_q.pop_front();
    if (got.kind !== exp_item.kind) begin
      $display("%0t: kind expected %0d actual %0d", $realtime, exp_item.kind, got.kind);
      err_cnt++;
    end
    if (got.best_score !== exp_item.best_score) begin
      $display("%0t: best_score expected %0d actual %0d", $realtime,
               exp_item.best_score, got.best_score);
      err_cnt++;
    end
    if (got.best_count !== exp_item.best_count) begin
      $display("%0t: best_count expected %0d actual %0d", $realtime,
               exp_item.best_count, got.best_count);
      err_cnt++;
    end
    if (got.row !== exp_item.row) begin
      $display("%0t: row expected %0d actual %0d", $realtime, exp_item.row, got.row);
      err_cnt++;
    end
    if (got.col !== exp_item.col) begin
      $display("%0t: col expected %0d actual %0d", $realtime, exp_item.col, got.col);
      err_cnt++;
    end
  endfunction

  // Monitor: every handshake is observed at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        predict_item(in_item_i);
        accepted_cnt++;
        in_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_e'(cfg_index_i))
          REG_ROWS:   rows_reg = cfg_data_i;
          REG_COLS:   cols_reg = cfg_data_i;
          REG_RADIUS: radius_reg = cfg_data_i;
          default: ;
        endcase
        cfg_cnt++;
      end
      if (out_valid && out_ready) begin
        check_result(out_item_o);
        result_cnt++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $realtime, idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Driver: items leave the pending queue in bursts with random gaps.
  always @(negedge clk_i) begin
    if (!(in_valid && !in_taken)) begin
      in_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        in_item_i <= pending_q.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: out_ready follows a stall pattern redrawn at random among four modes.
  always @(negedge clk_i) begin
    ready_cyc++;
    if (ready_cyc % 256 == 0) ready_mode = $urandom_range(0, 3);
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (ready_cyc % 8 == 0);
    endcase
  end

  task automatic push_item(op_e op, logic [CellBits-1:0] cell_val, logic last);
    in_item_t it;
    it.op = op;
    it.cell_value = cell_val;
    it.last_cell = last;
    pending_q.push_back(it);
    pushed_cnt++;
  endtask

  task automatic write_reg(reg_e idx, logic [DimW-1:0] val);
    int unsigned n;
    n = cfg_cnt;
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid <= 1'b1;
    do @(negedge clk_i); while (cfg_cnt == n);
    cfg_valid <= 1'b0;
  endtask

  // Fill styles: 0 random with frequent extremes, 1 all zero, 2 all max.
  task automatic load_grid(int unsigned n, int fill);
    logic [CellBits-1:0] v;
    for (int unsigned k = 0; k < n; k++) begin
      case (fill)
        1: v = '0;
        2: v = '1;
        default: begin
          case ($urandom_range(0, 5))
            0: v = '0;
            1: v = '1;
            default: v = CellBits'($urandom_range(0, 255));
          endcase
        end
      endcase
      push_item(OP_LOAD, v, k == n - 1);
    end
  endtask

  task automatic fetch_n(int unsigned n);
    for (int unsigned k = 0; k < n; k++)
      push_item(OP_FETCH, CellBits'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // Wait until every item is taken and every result has come back.
  task automatic drain();
    while (accepted_cnt != pushed_cnt || expected_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_dims(logic [DimW-1:0] r, logic [DimW-1:0] c, logic [DimW-1:0] d);
    write_reg(REG_ROWS, r);
    write_reg(REG_COLS, c);
    write_reg(REG_RADIUS, d);
  endtask

  initial begin
    int unsigned n, rand_start;
    rows_reg = DimW'(64);
    cols_reg = DimW'(64);
    radius_reg = DimW'(1);
    burst_left = 4;
    for (int k = 0; k < Depth; k++) begin
      grid_mem[k] = '0;
      score_mem[k] = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // All-zero grid: every cell ties at zero, then done twice.
    set_dims(3, 3, 1);
    load_grid(9, 1);
    fetch_n(11);
    drain();
    // All-max grid with a window larger than the grid.
    write_reg(REG_RADIUS, 126);
    load_grid(9, 2);
    fetch_n(2);
    drain();
    // Zero dimensions act as one.
    set_dims(0, 0, 0);
    load_grid(1, 2);
    fetch_n(2);
    drain();
    // Oversized values saturate to the grid limits.
    set_dims(127, 1, 127);
    load_grid(64, 0);
    fetch_n(3);
    drain();
    set_dims(1, 64, 126);
    load_grid(64, 0);
    fetch_n(3);
    drain();
    // Settings changed after the pass: fetches scan the new shape.
    set_dims(2, 5, 3);
    fetch_n(6);
    drain();

    // Random phases on small grids, some short loads and fetch-only phases.
    rand_start = pushed_cnt;
    while (pushed_cnt - rand_start < RandItems) begin
      if ($urandom_range(0, 2) == 0) begin
        set_dims(DimW'($urandom_range(0, 8)), DimW'($urandom_range(0, 8)),
                 ($urandom_range(0, 7) == 0) ? DimW'(126) : DimW'($urandom_range(0, 6)));
      end
      n = eff_dim(rows_reg, MaxRows) * eff_dim(cols_reg, MaxCols);
      if ($urandom_range(0, 5) != 0) begin
        load_grid(($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : n, 0);
        fetch_n($urandom_range(0, (n + 2 > 30) ? 30 : n + 2));
      end else begin
        fetch_n($urandom_range(1, 8));
      end
      drain();
    end

    repeat (50) @(negedge clk_i);
    if (err_cnt == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
